FILE: sv/scd_pkg.sv
// Shared types and constants of the sync command deframer.
// No dependencies; imported by every module of the block but scd_ram.
`default_nettype none

package scd_pkg;

  // Command bytes on the radio link
  localparam logic [7:0] CMD_SEQ_NAME   = 8'h01;
  localparam logic [7:0] CMD_MEDIA_NAME = 8'h02;
  localparam logic [7:0] CMD_SEQ_START  = 8'h03;
  localparam logic [7:0] CMD_MEDIA_START = 8'h04;
  localparam logic [7:0] CMD_SEQ_STOP   = 8'h05;
  localparam logic [7:0] CMD_MEDIA_STOP = 8'h06;
  localparam logic [7:0] CMD_SYNC       = 8'h07;
  localparam logic [7:0] CMD_BLANK      = 8'h09;
  localparam logic [7:0] CMD_UNLOCK     = 8'hFF;

  // Payload bytes of a sync frame
  localparam int unsigned SYNC_LEN = 9 - 1;

  // Entries of the result queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Event codes of a result item
  typedef enum logic [3:0] {
    EV_NAME_BYTE   = 4'd0,
    EV_SEQ_OPENED  = 4'd1,
    EV_SEQ_SAME    = 4'd2,
    EV_MEDIA_OPENED = 4'd3,
    EV_SEQ_START   = 4'd4,
    EV_MEDIA_START = 4'd5,
    EV_SEQ_STOP    = 4'd6,
    EV_MEDIA_STOP  = 4'd7,
    EV_SYNC        = 4'd8,
    EV_BLANK       = 4'd9,
    EV_UNLOCKED    = 4'd10,
    EV_UNKNOWN     = 4'd11,
    EV_NAME_LONG   = 4'd12
  } ev_t;

  // Framing phase of the front part
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEQ   = 2'd1,
    PH_MEDIA = 2'd2,
    PH_SYNC  = 2'd3
  } phase_t;

  // Compact result record handed from the front to the back
  typedef struct packed {
    ev_t         event_res;
    logic [7:0]  data_byte;
    logic [63:0] payload;
    logic        seq_active;
    logic        media_active;
  } res_rec_t;

  // One classified result leaving the front
  typedef struct packed {
    logic     vld;
    res_rec_t rec;
  } fe_res_t;

endpackage

`default_nettype wire

FILE: sv/sync_command_deframer_core.sv
// Top level of the sync command deframer: front framer, result queue and config port.
// Depends on scd_pkg, scd_front and scd_back.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------------
//   input    | in        | push / full        | in_rx_byte
//   result   | out       | empty / pop        | out_event_res .. out_forward
//   config   | in        | cfg_valid/cfg_ready| cfg_bridge_enable
//
// One byte is taken every cycle while full is low; its result, if any, can be
// popped from the next cycle on. The name compare reads the store ahead, addressed
// by the next count, so the byte-by-byte compare never stalls the input. A two-entry
// result queue holds results while pop is low; full rises only when both entries
// wait. Reset leaves the framer locked and the queue empty. cfg_ready is always high.
`default_nettype none

module sync_command_deframer_core #(
  parameter int NAME_DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    in_rx_byte,
  output logic               empty,
  input  wire logic          pop,
  output logic [3:0]         out_event_res,
  output logic [7:0]         out_data_byte,
  output logic signed [31:0] out_frame_number,
  output logic [31:0]        out_time_bits,
  output logic               out_seq_active,
  output logic               out_media_active,
  output logic               out_forward,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_bridge_enable
);

  import scd_pkg::*;

  logic    acc;
  fe_res_t fe_res;

  assign acc       = push && !full;
  assign cfg_ready = 1'b1;

  // Framing and classification
  scd_front #(
    .NAME_DEPTH(NAME_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .rx_byte(in_rx_byte),
    .res    (fe_res)
  );

  // Queue and result formatting
  scd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc              (acc),
    .res              (fe_res),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_bridge_enable(cfg_bridge_enable),
    .out_event_res    (out_event_res),
    .out_data_byte    (out_data_byte),
    .out_frame_number (out_frame_number),
    .out_time_bits    (out_time_bits),
    .out_seq_active   (out_seq_active),
    .out_media_active (out_media_active),
    .out_forward      (out_forward)
  );

endmodule

`default_nettype wire

FILE: sv/scd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the stored sequence name.
`default_nettype none

module scd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/scd_front.sv
// Front part: frames received bytes, compares sequence names and classifies events.
// Depends on scd_pkg and scd_ram.
`default_nettype none

module scd_front #(
  parameter int NAME_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic [7:0]       rx_byte,
  output scd_pkg::fe_res_t      res
);

  import scd_pkg::*;

  localparam int AW = $clog2(NAME_DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(NAME_DEPTH - 1);
  localparam logic [AW-1:0] SYNC_LAST = AW'(SYNC_LEN - 1);

  phase_t        phase_r, phase_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          locked_r, locked_nxt;
  logic          differs_r, differs_nxt;
  logic          seq_r, seq_nxt;
  logic          media_r, media_nxt;
  logic [63:0]   pay_r, pay_nxt;
  logic          e0_ok_r, e0_ok_nxt;
  logic          byp_r, byp_nxt;
  logic [7:0]    byp_d_r;
  logic          ra0_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    ram_q;
  logic [7:0]    rd_cur;
  logic          at_last;
  logic          rd_ne;
  logic          emit;
  ev_t           ev;

  // Name store; the read port always fetches the entry of the next count
  scd_ram #(
    .WIDTH(8),
    .DEPTH(NAME_DEPTH),
    .ADDR_W(AW)
  ) u_name_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt_nxt),
    .rdata(ram_q)
  );

  // Stored character at the current count, with write bypass and entry zero cleared at reset
  always_comb begin
    if (byp_r) begin
      rd_cur = byp_d_r;
    end else if (ra0_r && !e0_ok_r) begin
      rd_cur = 8'h00;
    end else begin
      rd_cur = ram_q;
    end
  end

  assign at_last = (cnt_r == LAST_IDX);
  assign rd_ne   = (rd_cur != rx_byte);

  // Next framing phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        PH_SEQ, PH_MEDIA: begin
          if (rx_byte == 8'h00 || at_last) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_SYNC: begin
          if (cnt_r == SYNC_LAST) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (!locked_r) begin
            priority if (rx_byte == CMD_SEQ_NAME) begin
              phase_nxt = PH_SEQ;
            end else if (rx_byte == CMD_MEDIA_NAME) begin
              phase_nxt = PH_MEDIA;
            end else if (rx_byte == CMD_SYNC) begin
              phase_nxt = PH_SYNC;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Counters, flags, store writes and the classified event
  always_comb begin
    cnt_nxt     = cnt_r;
    locked_nxt  = locked_r;
    differs_nxt = differs_r;
    seq_nxt     = seq_r;
    media_nxt   = media_r;
    pay_nxt     = pay_r;
    we          = 1'b0;
    waddr       = cnt_r;
    wdata       = rx_byte;
    emit        = 1'b0;
    ev          = EV_UNKNOWN;
    if (acc) begin
      unique case (phase_r)
        PH_SEQ, PH_MEDIA: begin
          if (rx_byte != 8'h00) begin
            if (at_last) begin
              // Name too long: drop it, and empty the store if it was already changed
              if (phase_r == PH_SEQ && differs_r) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = 8'h00;
                seq_nxt = 1'b0;
              end
              cnt_nxt     = '0;
              differs_nxt = 1'b0;
              emit        = 1'b1;
              ev          = EV_NAME_LONG;
            end else begin
              if (phase_r == PH_SEQ) begin
                we          = 1'b1;
                differs_nxt = differs_r | rd_ne;
              end
              cnt_nxt = cnt_r + 1'b1;
              emit    = 1'b1;
              ev      = EV_NAME_BYTE;
            end
          end else begin
            // Terminating zero closes the name
            cnt_nxt = '0;
            emit    = 1'b1;
            if (phase_r == PH_SEQ) begin
              we          = 1'b1;
              differs_nxt = 1'b0;
              if (differs_r || rd_ne) begin
                seq_nxt = (cnt_r != '0);
                ev      = EV_SEQ_OPENED;
              end else begin
                ev = EV_SEQ_SAME;
              end
            end else begin
              media_nxt = (cnt_r != '0);
              ev        = EV_MEDIA_OPENED;
            end
          end
        end
        PH_SYNC: begin
          pay_nxt = {rx_byte, pay_r[63:8]};
          if (cnt_r == SYNC_LAST) begin
            cnt_nxt = '0;
            emit    = seq_r | media_r;
            ev      = EV_SYNC;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        PH_IDLE: begin
          if (locked_r) begin
            if (rx_byte == CMD_UNLOCK) begin
              locked_nxt = 1'b0;
              emit       = 1'b1;
              ev         = EV_UNLOCKED;
            end
          end else begin
            unique case (rx_byte)
              CMD_SEQ_NAME, CMD_MEDIA_NAME: begin
                cnt_nxt     = '0;
                differs_nxt = 1'b0;
              end
              CMD_SEQ_START: begin
                emit = seq_r;
                ev   = EV_SEQ_START;
              end
              CMD_MEDIA_START: begin
                emit = media_r;
                ev   = EV_MEDIA_START;
              end
              CMD_SEQ_STOP: begin
                if (seq_r) begin
                  seq_nxt    = 1'b0;
                  locked_nxt = 1'b1;
                  we         = 1'b1;
                  waddr      = '0;
                  wdata      = 8'h00;
                  emit       = 1'b1;
                  ev         = EV_SEQ_STOP;
                end
              end
              CMD_MEDIA_STOP: begin
                if (media_r) begin
                  media_nxt = 1'b0;
                  emit      = 1'b1;
                  ev        = EV_MEDIA_STOP;
                end
              end
              CMD_SYNC: begin
                cnt_nxt = '0;
                pay_nxt = '0;
              end
              CMD_BLANK: begin
                emit = 1'b1;
                ev   = EV_BLANK;
              end
              CMD_UNLOCK: begin
                emit = 1'b1;
                ev   = EV_UNLOCKED;
              end
              default: begin
                emit = 1'b1;
                ev   = EV_UNKNOWN;
              end
            endcase
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // Bypass bookkeeping for the store read port
  assign e0_ok_nxt = e0_ok_r | (we && waddr == '0);
  assign byp_nxt   = we && (waddr == cnt_nxt);

  // Result towards the queue
  always_comb begin
    res.vld              = emit;
    res.rec.event_res    = ev;
    res.rec.data_byte    = rx_byte;
    res.rec.payload      = pay_nxt;
    res.rec.seq_active   = seq_nxt;
    res.rec.media_active = media_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      locked_r  <= 1'b1;
      differs_r <= 1'b0;
      seq_r     <= 1'b0;
      media_r   <= 1'b0;
      e0_ok_r   <= 1'b0;
      byp_r     <= 1'b0;
      ra0_r     <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      locked_r  <= locked_nxt;
      differs_r <= differs_nxt;
      seq_r     <= seq_nxt;
      media_r   <= media_nxt;
      e0_ok_r   <= e0_ok_nxt;
      byp_r     <= byp_nxt;
      ra0_r     <= (cnt_nxt == '0);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pay_r   <= pay_nxt;
    byp_d_r <= wdata;
  end

endmodule

`default_nettype wire

FILE: sv/scd_back.sv
// Back part: result queue, bridge enable register and result formatting.
// Depends on scd_pkg.
`default_nettype none

module scd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               acc,
  input  wire scd_pkg::fe_res_t   res,
  output logic                    full,
  output logic                    empty,
  input  wire logic               pop,
  input  wire logic               cfg_we,
  input  wire logic               cfg_bridge_enable,
  output logic [3:0]              out_event_res,
  output logic [7:0]              out_data_byte,
  output logic signed [31:0]      out_frame_number,
  output logic [31:0]             out_time_bits,
  output logic                    out_seq_active,
  output logic                    out_media_active,
  output logic                    out_forward
);

  import scd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  res_rec_t      entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          bridge_r;
  logic          do_wr;
  logic          do_rd;
  res_rec_t      head;

  assign full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = acc && res.vld;
  assign do_rd = pop && !empty;

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      bridge_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_we) begin
        bridge_r <= cfg_bridge_enable;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= res.rec;
    end
  end

  // Expand the head record into the result fields
  assign head = entry_r[rd_ptr_r];

  always_comb begin
    out_event_res    = head.event_res;
    out_data_byte    = (head.event_res == EV_NAME_BYTE) ? head.data_byte : 8'h00;
    out_frame_number = (head.event_res == EV_SYNC) ? signed'(head.payload[31:0]) : '0;
    out_time_bits    = (head.event_res == EV_SYNC) ? head.payload[63:32] : '0;
    out_seq_active   = head.seq_active;
    out_media_active = head.media_active;
    out_forward      = bridge_r;
  end

endmodule

`default_nettype wire

FILE: sv/scd_checker.sv
// Port-level checks of the sync command deframer, bound to the top level.
// Depends on scd_pkg and sync_command_deframer_core.
`default_nettype none

module scd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [3:0]  out_event_res,
  input wire logic [7:0]  out_data_byte,
  input wire logic [31:0] out_frame_number,
  input wire logic [31:0] out_time_bits
);

  import scd_pkg::*;

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting after reset");

  // A waiting result stays put until it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_event_res) && $stable(out_data_byte)))
    else $error("waiting result changed before pop");

  // Only defined event codes are shown
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_event_res <= 4'(EV_NAME_LONG)))
    else $error("undefined event code");

  // Sync fields are zero on every other event
  a_sync_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_res != 4'(EV_SYNC)) |-> (out_frame_number == '0 && out_time_bits == '0))
    else $error("sync fields set on a non-sync event");

  // The data byte is zero on every event but a name byte
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_res != 4'(EV_NAME_BYTE)) |-> (out_data_byte == 8'h00))
    else $error("data byte set on an event without a character");

endmodule

bind sync_command_deframer_core scd_checker u_scd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_event_res   (out_event_res),
  .out_data_byte   (out_data_byte),
  .out_frame_number(out_frame_number),
  .out_time_bits   (out_time_bits)
);

`default_nettype wire

FILE: dv/sync_command_deframer_core_tb.sv
// Self-checking testbench of sync_command_deframer_core: byte stimulus, event prediction
// and result checking. Depends on scd_pkg and the sync_command_deframer_core RTL.
`default_nettype none

module sync_command_deframer_core_tb;
  import scd_pkg::*;

  localparam int unsigned NAME_DEPTH   = 256;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned ITEM_TARGET  = 1250;

  // One decoded event as it should leave the block.
  typedef struct packed {
    ev_t         ev;
    logic [7:0]  data;
    logic [31:0] frame;
    logic [31:0] tbits;
    logic        seq_on;
    logic        media_on;
    logic        fwd;
  } deframer_event_t;

  // Predicts the events of the deframer from the accepted bytes and checks the
  // popped results against them in order.
  class deframer_ledger #(int unsigned DEPTH = 256);
    logic            bridge_en;
    logic            locked;
    phase_t          phase;
    int unsigned     count;
    logic [63:0]     sync_bytes;
    logic [7:0]      store [DEPTH];
    logic            differs;
    logic            seq_on;
    logic            media_on;
    deframer_event_t pending_events [$];
    int unsigned     errors;

    function new();
      bridge_en  = 1'b0;
      locked     = 1'b1;
      phase      = PH_IDLE;
      count      = 0;
      sync_bytes = '0;
      differs    = 1'b0;
      seq_on     = 1'b0;
      media_on   = 1'b0;
      errors     = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    // Queues an event carrying the flags as they stand after it.
    function void emit(ev_t ev, logic [7:0] data = 8'h00, logic [31:0] frame = 32'h0,
                       logic [31:0] tbits = 32'h0);
      deframer_event_t e;
      e.ev       = ev;
      e.data     = data;
      e.frame    = frame;
      e.tbits    = tbits;
      e.seq_on   = seq_on;
      e.media_on = media_on;
      e.fwd      = bridge_en;
      pending_events.push_back(e);
    endfunction

    // One byte inside a sequence or media name, compared against the store for sequences.
    function void name_char(logic [7:0] b);
      int unsigned idx;
      logic        is_seq;
      idx    = (count >= DEPTH) ? DEPTH - 1 : count;
      is_seq = (phase == PH_SEQ);
      if (b != 8'h00) begin
        if (idx >= DEPTH - 1) begin
          // The name has run past the store: a differing sequence name empties it.
          if (is_seq && differs) begin
            store[0] = 8'h00;
            seq_on   = 1'b0;
          end
          phase   = PH_IDLE;
          count   = 0;
          differs = 1'b0;
          emit(EV_NAME_LONG);
          return;
        end
        if (is_seq) begin
          if (store[idx] != b) differs = 1'b1;
          store[idx] = b;
        end
        count = idx + 1;
        emit(EV_NAME_BYTE, b);
        return;
      end
      phase = PH_IDLE;
      count = 0;
      if (is_seq) begin
        if (store[idx] != 8'h00) differs = 1'b1;
        store[idx] = 8'h00;
        if (!differs) begin
          emit(EV_SEQ_SAME);
          return;
        end
        differs = 1'b0;
        seq_on  = (idx != 0);
        emit(EV_SEQ_OPENED);
        return;
      end
      media_on = (idx != 0);
      emit(EV_MEDIA_OPENED);
    endfunction

    // Notes one accepted input byte and predicts the event it causes, if any.
    function void take_byte(logic [7:0] b);
      if (phase == PH_SEQ || phase == PH_MEDIA) begin
        name_char(b);
        return;
      end
      if (phase == PH_SYNC) begin
        sync_bytes = {b, sync_bytes[63:8]};
        count      = (count + 1) & 32'hFF;
        if (count < SYNC_LEN) return;
        phase = PH_IDLE;
        count = 0;
        if (seq_on || media_on) emit(EV_SYNC, 8'h00, sync_bytes[31:0], sync_bytes[63:32]);
        return;
      end
      // While locked only the unlock byte gets through.
      if (locked) begin
        if (b == CMD_UNLOCK) begin
          locked = 1'b0;
          emit(EV_UNLOCKED);
        end
        return;
      end
      case (b)
        CMD_SEQ_NAME, CMD_MEDIA_NAME: begin
          phase   = (b == CMD_SEQ_NAME) ? PH_SEQ : PH_MEDIA;
          count   = 0;
          differs = 1'b0;
        end
        CMD_SEQ_START: begin
          if (seq_on) emit(EV_SEQ_START);
        end
        CMD_MEDIA_START: begin
          if (media_on) emit(EV_MEDIA_START);
        end
        CMD_SEQ_STOP: begin
          if (seq_on) begin
            seq_on   = 1'b0;
            store[0] = 8'h00;
            locked   = 1'b1;
            emit(EV_SEQ_STOP);
          end
        end
        CMD_MEDIA_STOP: begin
          if (media_on) begin
            media_on = 1'b0;
            emit(EV_MEDIA_STOP);
          end
        end
        CMD_SYNC: begin
          phase      = PH_SYNC;
          count      = 0;
          sync_bytes = '0;
        end
        CMD_BLANK: emit(EV_BLANK);
        CMD_UNLOCK: emit(EV_UNLOCKED);
        default: emit(EV_UNKNOWN);
      endcase
    endfunction

    // Compares one popped result with the oldest predicted event.
    function void check_event(logic [3:0] ev, logic [7:0] data, logic [31:0] frame,
                              logic [31:0] tbits, logic seq, logic media, logic fwd);
      deframer_event_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("result with event %0d arrived with nothing expected", ev));
        return;
      end
      want = pending_events.pop_front();
      if (ev !== want.ev)
        report($sformatf("event_res got %0d want %0d", ev, want.ev));
      if (data !== want.data)
        report($sformatf("data_byte got 0x%02h want 0x%02h (event %0d)", data, want.data,
                         want.ev));
      if (frame !== want.frame)
        report($sformatf("frame_number got 0x%08h want 0x%08h (event %0d)", frame,
                         want.frame, want.ev));
      if (tbits !== want.tbits)
        report($sformatf("time_bits got 0x%08h want 0x%08h (event %0d)", tbits, want.tbits,
                         want.ev));
      if (seq !== want.seq_on)
        report($sformatf("seq_active got %b want %b (event %0d)", seq, want.seq_on, want.ev));
      if (media !== want.media_on)
        report($sformatf("media_active got %b want %b (event %0d)", media, want.media_on,
                         want.ev));
      if (fwd !== want.fwd)
        report($sformatf("forward got %b want %b (event %0d)", fwd, want.fwd, want.ev));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               empty;
  logic               pop = 1'b0;
  logic [3:0]         out_event_res;
  logic [7:0]         out_data_byte;
  logic signed [31:0] out_frame_number;
  logic [31:0]        out_time_bits;
  logic               out_seq_active;
  logic               out_media_active;
  logic               out_forward;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_bridge_enable = 1'b0;

  deframer_ledger #(NAME_DEPTH) ledger;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  logic [7:0]  seq_name [$];
  logic        tx_calm = 1'b0;
  int unsigned tx_left = 0;
  logic        rx_calm = 1'b0;
  int unsigned rx_left = 0;

  sync_command_deframer_core #(
    .NAME_DEPTH(NAME_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_event_res    (out_event_res),
    .out_data_byte    (out_data_byte),
    .out_frame_number (out_frame_number),
    .out_time_bits    (out_time_bits),
    .out_seq_active   (out_seq_active),
    .out_media_active (out_media_active),
    .out_forward      (out_forward),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bridge_enable(cfg_bridge_enable)
  );

  // Clock of period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("sync_command_deframer_core verification failed");
      $finish;
    end
  end

  // Offers one byte after a random gap and holds it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (tx_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(10, 60);
    end
    tx_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    ledger.take_byte(b);
    bytes_sent++;
  endtask

  // A name frame: command byte, characters, then the closing byte.
  task automatic send_name(input logic [7:0] cmd, input logic [7:0] chars [$],
                           input logic [7:0] tail);
    send_byte(cmd);
    foreach (chars[i]) send_byte(chars[i]);
    send_byte(tail);
    if (cmd == CMD_SEQ_NAME && tail == 8'h00) seq_name = chars;
  endtask

  task automatic send_sync(input logic [31:0] frame, input logic [31:0] tbits);
    logic [63:0] body;
    body = {tbits, frame};
    send_byte(CMD_SYNC);
    for (int i = 0; i < 8; i++) send_byte(body[8*i +: 8]);
  endtask

  // Stops sending and lets every expected result come out, then a little more.
  task automatic settle();
    push <= 1'b0;
    while (ledger.pending_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_bridge(input logic value);
    cfg_valid         <= 1'b1;
    cfg_bridge_enable <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid        <= 1'b0;
    ledger.bridge_en = value;
  endtask

  // Hand-picked items: locking, every command but media start, empty names and extreme sync fields.
  task automatic directed_items();
    logic [7:0] none [$];
    logic [7:0] short_name [$];
    short_name = '{8'h80, 8'h7F};
    send_byte(8'h41);
    send_byte(CMD_SEQ_STOP);
    send_byte(CMD_UNLOCK);
    send_byte(CMD_UNLOCK);
    send_byte(CMD_BLANK);
    send_byte(8'h00);
    send_byte(8'hFE);
    // Start, stop and sync with nothing active say nothing.
    send_byte(CMD_SEQ_START);
    send_byte(CMD_MEDIA_STOP);
    send_sync(32'h7FFF_FFFF, 32'h0000_0000);
    // Empty names: the sequence matches the cleared store, the media stays inactive.
    send_name(CMD_SEQ_NAME, none, 8'h00);
    send_name(CMD_MEDIA_NAME, none, 8'h00);
    send_name(CMD_SEQ_NAME, short_name, 8'h00);
    send_name(CMD_SEQ_NAME, short_name, 8'h00);
    send_byte(CMD_SEQ_START);
    send_sync(32'h8000_0000, 32'hFFFF_FFFF);
    // Stopping the sequence locks the block, so the blank vanishes.
    send_byte(CMD_SEQ_STOP);
    send_byte(CMD_BLANK);
    send_byte(CMD_UNLOCK);
  endtask

  // Names at the length limit, with and without a difference from the store.
  task automatic long_names();
    logic [7:0] tall [$];
    int unsigned k;
    send_byte(CMD_UNLOCK);
    repeat (NAME_DEPTH - 1) tall.push_back(8'($urandom_range(1, 255)));
    send_name(CMD_SEQ_NAME, tall, 8'h00);
    send_name(CMD_SEQ_NAME, tall, 8'($urandom_range(1, 255)));
    send_byte(CMD_SEQ_START);
    k = $urandom_range(0, NAME_DEPTH - 2);
    tall[k] = (tall[k] == 8'hFF) ? 8'h01 : tall[k] + 8'h01;
    send_name(CMD_SEQ_NAME, tall, 8'($urandom_range(1, 255)));
    send_name(CMD_MEDIA_NAME, tall, 8'($urandom_range(1, 255)));
    send_byte(CMD_MEDIA_START);
  endtask

  // One random frame; mostly well formed, with noise and mutated names mixed in.
  task automatic random_frame();
    logic [7:0]  chars [$];
    logic [7:0]  cmd;
    int unsigned pick;
    int unsigned r;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (ledger.locked) begin
      if (pick < 30) send_byte(8'($urandom_range(0, 254)));
      else send_byte(CMD_UNLOCK);
    end else if (pick < 40) begin
      cmd = (pick < 25) ? CMD_SEQ_NAME : CMD_MEDIA_NAME;
      r   = $urandom_range(0, 19);
      if (r == 0) begin
        // Empty name.
      end else if (r < 9 && seq_name.size() != 0) begin
        chars = seq_name;
        if (r >= 6) begin
          k        = $urandom_range(0, chars.size() - 1);
          chars[k] = 8'($urandom_range(1, 255));
        end
        if (r == 8 && chars.size() > 1) void'(chars.pop_back());
      end else begin
        repeat ($urandom_range(1, 12)) chars.push_back(8'($urandom_range(1, 255)));
      end
      send_name(cmd, chars, 8'h00);
    end else if (pick < 55) begin
      send_sync($urandom, $urandom);
    end else if (pick < 70) begin
      r = $urandom_range(0, 9);
      if (r < 3) send_byte(CMD_SEQ_START);
      else if (r < 6) send_byte(CMD_MEDIA_START);
      else if (r < 8) send_byte(CMD_MEDIA_STOP);
      else send_byte(CMD_SEQ_STOP);
    end else if (pick < 78) begin
      send_byte(CMD_BLANK);
    end else if (pick < 83) begin
      send_byte(CMD_UNLOCK);
    end else if (pick < 90) begin
      r = $urandom_range(0, 2);
      if (r == 0) send_byte(8'h00);
      else if (r == 1) send_byte(8'h08);
      else send_byte(8'($urandom_range(10, 254)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: pops after a random stall and checks every result taken.
  initial begin
    int unsigned gap;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_left == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        rx_left = $urandom_range(10, 60);
      end
      rx_left--;
      gap = rx_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      ledger.check_event(out_event_res, out_data_byte, out_frame_number, out_time_bits,
                         out_seq_active, out_media_active, out_forward);
    end
  end

  // Main sequence: reset, phases under different bridge settings, then the verdict.
  initial begin
    int unsigned target;
    ledger = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_bridge(1'b1);
    directed_items();
    settle();
    write_bridge(1'b0);
    long_names();
    settle();
    // Random traffic fills the rest of the item budget, split over both bridge settings.
    write_bridge(1'b1);
    target = (bytes_sent + ITEM_TARGET) / 2;
    while (bytes_sent < target) random_frame();
    settle();
    write_bridge(1'b0);
    while (bytes_sent < ITEM_TARGET) random_frame();
    settle();
    if (ledger.errors == 0) begin
      $display("sync_command_deframer_core verification clean");
    end else begin
      $display("sync_command_deframer_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
